FILE: design/vfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vfd_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_NUM_CHANNELS = 3'd0;
  localparam logic [2:0] REG_SIZE_X       = 3'd1;
  localparam logic [2:0] REG_SIZE_Y       = 3'd2;
  localparam logic [2:0] REG_SIZE_Z       = 3'd3;
  localparam logic [2:0] REG_DIFF_AXIS    = 3'd4;
  localparam logic [2:0] REG_DIFF_MODE    = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;

  // Axis and mode codes as written to the registers
  localparam logic [1:0] AXIS_X   = 2'd0;
  localparam logic [1:0] AXIS_Y   = 2'd1;
  localparam logic [1:0] CODE_FWD = 2'd0;
  localparam logic [1:0] CODE_BWD = 2'd1;

  // Input item kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  localparam int MAX_Z = 1024;
  localparam int Z_W   = $clog2(MAX_Z);

  localparam int SAMPLE_W    = 16;
  localparam int DIFF_W      = 17;
  localparam int WORD_W      = 2 * SAMPLE_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    DM_FWD,
    DM_BWD,
    DM_CEN
  } diff_mode_t;

endpackage

`default_nettype wire

FILE: design/vfd_delay_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module vfd_delay_mem #(
  parameter int DEPTH = 65536,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr_a,
  input  wire logic [AW-1:0]    rd_addr_b,
  output logic      [WIDTH-1:0] rd_data_a,
  output logic      [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Reads return the old word when the write hits the same entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

FILE: design/volume_finite_difference.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake            Payload
// in_      in   tvalid/tready        tdata: re, im; tuser: req_type
// out_     out  tvalid/tready        tdata: diff re, diff im; tlast: last
// cfg_     in   we (no back-pressure) index, wdata
//
// One transaction per cycle sustained while out_tready is high; a result
// passes the read stage and output register. The rate is set by the delay
// store: one write port, two read ports (here, behind taps) serve each item.
// Reset clears counters and pipeline valids; the delay store holds no reset
// and no clearing pass is run. out_tready low holds the output register; the
// read stage then fills and in_tready drops. DELAY_DEPTH is a power of two
// greater than the largest axis stride.

module volume_finite_difference #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_X        = 64,
  parameter int MAX_Y        = 64,
  parameter int DELAY_DEPTH  = 65536
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: in_re [15:0], in_im [31:16]
  input  wire logic [vfd_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: req_type [0]
  input  wire logic                                in_tuser,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // out_tdata: out_re [16:0], out_im [33:17], zero fill [39:34]
  output logic      [vfd_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                     out_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_we,
  input  wire logic [vfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [vfd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import vfd_pkg::*;

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int X_W  = $clog2(MAX_X);
  localparam int Y_W  = $clog2(MAX_Y);
  localparam int AW   = $clog2(DELAY_DEPTH);

  // Configuration
  logic [3:0]  nch_r;
  logic [6:0]  sx_r;
  logic [6:0]  sy_r;
  logic [10:0] sz_r;
  logic [1:0]  axis_r;
  logic [1:0]  mode_r;
  logic        cfg_hit;

  logic [CH_W-1:0] c_last;
  logic [X_W-1:0]  x_last;
  logic [Y_W-1:0]  y_last;
  logic [Z_W-1:0]  z_last;
  logic            axis_x;
  logic            axis_y;
  diff_mode_t      mode_sel;

  // Position counters
  logic [CH_W-1:0] ich_r, ich_nxt, och_r, och_nxt;
  logic [X_W-1:0]  ix_r, ix_nxt, ox_r, ox_nxt;
  logic [Y_W-1:0]  iy_r, iy_nxt, oy_r, oy_nxt;
  logic [Z_W-1:0]  iz_r, iz_nxt, oz_r, oz_nxt;
  logic            in_done_r, in_done_nxt;
  logic [AW-1:0]   wa_r, wa_nxt, oa_r, oa_nxt, ba_r, ba_nxt;

  logic in_fire;
  logic advance;
  logic drop;
  logic fill_pos;
  logic gives;
  logic mem_we;
  logic in_last_pos;
  logic out_last_pos;
  logic interior;

  // Read stage
  logic                       s1_valid_r;
  logic signed [SAMPLE_W-1:0] s1_re_r;
  logic signed [SAMPLE_W-1:0] s1_im_r;
  logic                       s1_int_r;
  logic                       s1_last_r;
  diff_mode_t                 s1_mode_r;
  logic [WORD_W-1:0]          rd_here;
  logic [WORD_W-1:0]          rd_behind;

  // Output stage
  logic                     out_valid_r;
  logic signed [DIFF_W-1:0] out_re_r;
  logic signed [DIFF_W-1:0] out_im_r;
  logic                     out_last_r;
  logic signed [DIFF_W-1:0] dre;
  logic signed [DIFF_W-1:0] dim;

  assign cfg_hit = cfg_we && (cfg_index <= REG_DIFF_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nch_r  <= 4'd1;
      sx_r   <= 7'd64;
      sy_r   <= 7'd64;
      sz_r   <= 11'd64;
      axis_r <= AXIS_X;
      mode_r <= CODE_FWD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_CHANNELS: nch_r  <= cfg_wdata[3:0];
        REG_SIZE_X:       sx_r   <= cfg_wdata[6:0];
        REG_SIZE_Y:       sy_r   <= cfg_wdata[6:0];
        REG_SIZE_Z:       sz_r   <= cfg_wdata;
        REG_DIFF_AXIS:    axis_r <= cfg_wdata[1:0];
        REG_DIFF_MODE:    mode_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Saturate sizes and turn them into last indexes
  always_comb begin
    int c_i;
    int x_i;
    int y_i;
    int z_i;
    c_i = int'(nch_r);
    x_i = int'(sx_r);
    y_i = int'(sy_r);
    z_i = int'(sz_r);
    if (c_i < 1) c_i = 1;
    else if (c_i > MAX_CHANNELS) c_i = MAX_CHANNELS;
    if (x_i < 3) x_i = 3;
    else if (x_i > MAX_X) x_i = MAX_X;
    if (y_i < 3) y_i = 3;
    else if (y_i > MAX_Y) y_i = MAX_Y;
    if (z_i < 3) z_i = 3;
    else if (z_i > MAX_Z) z_i = MAX_Z;
    c_last = CH_W'(c_i - 1);
    x_last = X_W'(x_i - 1);
    y_last = Y_W'(y_i - 1);
    z_last = Z_W'(z_i - 1);
  end

  assign axis_x = (axis_r == AXIS_X);
  assign axis_y = (axis_r == AXIS_Y);

  always_comb begin
    case (mode_r)
      CODE_FWD: mode_sel = DM_FWD;
      CODE_BWD: mode_sel = DM_BWD;
      default:  mode_sel = DM_CEN;
    endcase
  end

  // Item classification
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign drop     = !in_done_r && (in_tuser == REQ_FLUSH);
  assign fill_pos = axis_x ? (ix_r == '0 && iy_r == '0 && iz_r == '0) :
                    axis_y ? (iy_r == '0 && iz_r == '0) :
                             (iz_r == '0);
  assign gives    = !drop && (in_done_r || !fill_pos);
  assign mem_we   = in_fire && !in_done_r && !drop;

  assign in_last_pos  = (ich_r == c_last) && (ix_r == x_last) &&
                        (iy_r == y_last) && (iz_r == z_last);
  assign out_last_pos = (och_r == c_last) && (ox_r == x_last) &&
                        (oy_r == y_last) && (oz_r == z_last);
  assign interior     = (ox_r != '0) && (ox_r != x_last) &&
                        (oy_r != '0) && (oy_r != y_last) &&
                        (oz_r != '0) && (oz_r != z_last);

  always_comb begin
    ich_nxt     = ich_r;
    ix_nxt      = ix_r;
    iy_nxt      = iy_r;
    iz_nxt      = iz_r;
    in_done_nxt = in_done_r;
    wa_nxt      = wa_r;
    och_nxt     = och_r;
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    oz_nxt      = oz_r;
    oa_nxt      = oa_r;
    ba_nxt      = ba_r;

    if (mem_we) begin
      wa_nxt = wa_r + 1'b1;
      if (in_last_pos) begin
        in_done_nxt = 1'b1;
      end
      if (ich_r == c_last) begin
        ich_nxt = '0;
        if (ix_r == x_last) begin
          ix_nxt = '0;
          if (iy_r == y_last) begin
            iy_nxt = '0;
            iz_nxt = (iz_r == z_last) ? '0 : iz_r + 1'b1;
          end else begin
            iy_nxt = iy_r + 1'b1;
          end
        end else begin
          ix_nxt = ix_r + 1'b1;
        end
      end else begin
        ich_nxt = ich_r + 1'b1;
      end
    end

    if (in_fire && !drop) begin
      if (!gives) begin
        // behind tap trails the here tap by one stride
        ba_nxt = ba_r - 1'b1;
      end else begin
        oa_nxt = oa_r + 1'b1;
        ba_nxt = ba_r + 1'b1;
        if (och_r == c_last) begin
          och_nxt = '0;
          if (ox_r == x_last) begin
            ox_nxt = '0;
            if (oy_r == y_last) begin
              oy_nxt = '0;
              oz_nxt = (oz_r == z_last) ? '0 : oz_r + 1'b1;
            end else begin
              oy_nxt = oy_r + 1'b1;
            end
          end else begin
            ox_nxt = ox_r + 1'b1;
          end
        end else begin
          och_nxt = och_r + 1'b1;
        end
      end
    end

    // Restart the volume after its final result or on any register write
    if (cfg_hit || (in_fire && gives && out_last_pos)) begin
      ich_nxt     = '0;
      ix_nxt      = '0;
      iy_nxt      = '0;
      iz_nxt      = '0;
      in_done_nxt = 1'b0;
      wa_nxt      = '0;
      och_nxt     = '0;
      ox_nxt      = '0;
      oy_nxt      = '0;
      oz_nxt      = '0;
      oa_nxt      = '0;
      ba_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ich_r     <= '0;
      ix_r      <= '0;
      iy_r      <= '0;
      iz_r      <= '0;
      in_done_r <= 1'b0;
      wa_r      <= '0;
      och_r     <= '0;
      ox_r      <= '0;
      oy_r      <= '0;
      oz_r      <= '0;
      oa_r      <= '0;
      ba_r      <= '0;
    end else begin
      ich_r     <= ich_nxt;
      ix_r      <= ix_nxt;
      iy_r      <= iy_nxt;
      iz_r      <= iz_nxt;
      in_done_r <= in_done_nxt;
      wa_r      <= wa_nxt;
      och_r     <= och_nxt;
      ox_r      <= ox_nxt;
      oy_r      <= oy_nxt;
      oz_r      <= oz_nxt;
      oa_r      <= oa_nxt;
      ba_r      <= ba_nxt;
    end
  end

  vfd_delay_mem #(
    .DEPTH (DELAY_DEPTH),
    .WIDTH (WORD_W)
  ) u_delay (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (wa_r),
    .wr_data   (in_tdata[WORD_W-1:0]),
    .rd_en     (in_fire),
    .rd_addr_a (oa_r),
    .rd_addr_b (ba_r),
    .rd_data_a (rd_here),
    .rd_data_b (rd_behind)
  );

  // Read stage: hold the ahead sample beside the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_fire && gives;
    end
    if (in_fire) begin
      // flush items carry no ahead sample
      s1_re_r   <= in_done_r ? '0 : in_tdata[SAMPLE_W-1:0];
      s1_im_r   <= in_done_r ? '0 : in_tdata[WORD_W-1:SAMPLE_W];
      s1_int_r  <= interior;
      s1_last_r <= out_last_pos;
      s1_mode_r <= mode_sel;
    end
  end

  always_comb begin
    logic signed [DIFF_W-1:0] a_re, h_re, b_re, a_im, h_im, b_im, t_re, t_im;
    a_re = DIFF_W'(s1_re_r);
    a_im = DIFF_W'(s1_im_r);
    h_re = DIFF_W'($signed(rd_here[SAMPLE_W-1:0]));
    h_im = DIFF_W'($signed(rd_here[WORD_W-1:SAMPLE_W]));
    b_re = DIFF_W'($signed(rd_behind[SAMPLE_W-1:0]));
    b_im = DIFF_W'($signed(rd_behind[WORD_W-1:SAMPLE_W]));
    t_re = a_re - b_re;
    t_im = a_im - b_im;
    case (s1_mode_r)
      DM_FWD: begin
        dre = a_re - h_re;
        dim = a_im - h_im;
      end
      DM_BWD: begin
        dre = h_re - b_re;
        dim = h_im - b_im;
      end
      default: begin
        dre = t_re >>> 1;
        dim = t_im >>> 1;
      end
    endcase
    if (!s1_int_r) begin
      dre = '0;
      dim = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
    if (advance && s1_valid_r) begin
      out_re_r   <= dre;
      out_im_r   <= dim;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2 * DIFF_W){1'b0}}, out_im_r, out_re_r};

  // A flush transaction after the volume always yields a result
  a_flush_gives: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_done_r && !cfg_hit) |=> s1_valid_r)
    else $error("flush transaction produced no result");

  // The write never lands on the entry read as the here tap
  a_no_here_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && gives) |-> (wa_r != oa_r))
    else $error("delay write collides with here tap");

  // A held read stage keeps its item while the output stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && out_valid_r))
    else $error("read stage lost an item under stall");

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import vfd_pkg::*;

  localparam int MAX_CH        = 8;
  localparam int MAX_XY        = 64;
  localparam int DEPTH         = 65536;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int ITEM_TARGET   = 1200;
  localparam int PRINT_CAP     = 40;

  // Indexes past the register list; writes there must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_PAST_END_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_PAST_END_HI = 3'd7;

  localparam bit [SAMPLE_W-1:0] EDGE_VALS [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

  typedef struct packed {
    logic [DIFF_W-1:0] re;
    logic [DIFF_W-1:0] im;
    logic              last;
  } diff_result_t;

  class diff_scoreboard;
    bit [3:0]         reg_ch;
    bit [6:0]         reg_x;
    bit [6:0]         reg_y;
    bit [10:0]        reg_z;
    bit [1:0]         reg_axis;
    bit [1:0]         reg_mode;
    bit [WORD_W-1:0]  delay_mem [DEPTH];
    int unsigned      in_pos;
    int unsigned      out_pos;
    diff_result_t     expected_q [$];
    int               errors;

    function new();
      reg_ch   = 1;
      reg_x    = 64;
      reg_y    = 64;
      reg_z    = 64;
      reg_axis = AXIS_X;
      reg_mode = CODE_FWD;
      in_pos   = 0;
      out_pos  = 0;
      errors   = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void dims(output int unsigned c, nx, ny, nz, stride, total);
      c  = clamp(reg_ch, 1, MAX_CH);
      nx = clamp(reg_x, 3, MAX_XY);
      ny = clamp(reg_y, 3, MAX_XY);
      nz = clamp(reg_z, 3, MAX_Z);
      if (reg_axis == AXIS_X) stride = c;
      else if (reg_axis == AXIS_Y) stride = c * nx;
      else stride = c * nx * ny;
      total = c * nx * ny * nz;
    endfunction

    function void apply_reg(bit [CFG_INDEX_W-1:0] index, bit [CFG_DATA_W-1:0] value);
      case (index)
        REG_NUM_CHANNELS: reg_ch   = value[3:0];
        REG_SIZE_X:       reg_x    = value[6:0];
        REG_SIZE_Y:       reg_y    = value[6:0];
        REG_SIZE_Z:       reg_z    = value[10:0];
        REG_DIFF_AXIS:    reg_axis = value[1:0];
        REG_DIFF_MODE:    reg_mode = value[1:0];
        default:          return;
      endcase
      // any register write restarts the volume
      in_pos  = 0;
      out_pos = 0;
    endfunction

    function bit [DIFF_W-1:0] diff_of(bit [SAMPLE_W-1:0] ahead, bit [SAMPLE_W-1:0] here,
                                      bit [SAMPLE_W-1:0] behind);
      int         a;
      int         h;
      int         b;
      int         d;
      diff_mode_t m;
      a = $signed(ahead);
      h = $signed(here);
      b = $signed(behind);
      m = (reg_mode > DM_CEN) ? DM_CEN : diff_mode_t'(reg_mode);
      case (m)
        DM_FWD:  d = a - h;
        DM_BWD:  d = h - b;
        default: d = (a - b) >>> 1;
      endcase
      return d[DIFF_W-1:0];
    endfunction

    function void note_input(bit kind, bit [SAMPLE_W-1:0] re, bit [SAMPLE_W-1:0] im);
      int unsigned     c, nx, ny, nz, stride, total;
      int unsigned     p, v, px, py, pz;
      bit [WORD_W-1:0] ahead_w;
      bit [WORD_W-1:0] here_w;
      bit [WORD_W-1:0] behind_w;
      bit              is_sample;
      diff_result_t    r;
      dims(c, nx, ny, nz, stride, total);
      if (in_pos > total) in_pos = total;
      is_sample = in_pos < total;
      ahead_w = '0;
      if (is_sample) begin
        // drop a flush that comes before the volume is complete
        if (kind == REQ_FLUSH) return;
        ahead_w = {im, re};
        if (in_pos < stride) begin
          delay_mem[in_pos % DEPTH] = ahead_w;
          in_pos++;
          return;
        end
      end
      p        = out_pos;
      here_w   = delay_mem[p % DEPTH];
      behind_w = delay_mem[(p + DEPTH - stride % DEPTH) % DEPTH];
      v  = p / c;
      px = v % nx;
      v  = v / nx;
      py = v % ny;
      pz = v / ny;
      r = '0;
      if (px != 0 && px != nx - 1 && py != 0 && py != ny - 1 && pz != 0 && pz != nz - 1) begin
        r.re = diff_of(ahead_w[15:0], here_w[15:0], behind_w[15:0]);
        r.im = diff_of(ahead_w[31:16], here_w[31:16], behind_w[31:16]);
      end
      if (is_sample) begin
        delay_mem[in_pos % DEPTH] = ahead_w;
        in_pos++;
      end
      out_pos++;
      r.last = (p + 1 >= total);
      if (r.last) begin
        in_pos  = 0;
        out_pos = 0;
      end
      expected_q.push_back(r);
    endfunction

    function void flag(string what, logic [DIFF_W-1:0] exp_v, logic [DIFF_W-1:0] act_v);
      errors++;
      if (errors <= PRINT_CAP)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
      diff_result_t r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: result mismatch, expected none, actual tdata %h last %b",
                   $time, tdata, tlast);
        return;
      end
      r = expected_q.pop_front();
      if (tdata[DIFF_W-1:0] !== r.re) flag("out_re", r.re, tdata[DIFF_W-1:0]);
      if (tdata[2*DIFF_W-1:DIFF_W] !== r.im) flag("out_im", r.im, tdata[2*DIFF_W-1:DIFF_W]);
      if (tlast !== r.last) flag("last", DIFF_W'(r.last), DIFF_W'(tlast));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  diff_scoreboard sb;
  int unsigned    items_sent;
  int             gap_pct;
  bit             hold_off_req;

  volume_finite_difference dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  function automatic bit [SAMPLE_W-1:0] pick_component();
    return ($urandom_range(0, 7) == 0) ? EDGE_VALS[$urandom_range(0, 3)] : SAMPLE_W'($urandom);
  endfunction

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1)
      sb.check_result(out_tdata, out_tlast);
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int stretch;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_tready <= 1'b1;
        stretch = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
        for (int k = 0; k < stretch && !hold_off_req; k++) @(posedge clk);
        if (!hold_off_req && $urandom_range(0, 2) != 0) begin
          out_tready <= 1'b0;
          repeat (pick_gap()) @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(bit kind, bit [SAMPLE_W-1:0] re, bit [SAMPLE_W-1:0] im);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {im, re};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_input(kind, re, im);
  endtask

  // Hold input until every expected result is out, then let the pipe settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(bit [CFG_INDEX_W-1:0] index, int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.apply_reg(index, CFG_DATA_W'(value));
  endtask

  task automatic set_config(int unsigned ch, int unsigned nx, int unsigned ny, int unsigned nz,
                            int unsigned axis, int unsigned mode);
    wait_idle();
    cfg_write(REG_NUM_CHANNELS, ch);
    cfg_write(REG_SIZE_X, nx);
    cfg_write(REG_SIZE_Y, ny);
    cfg_write(REG_SIZE_Z, nz);
    cfg_write(REG_DIFF_AXIS, axis);
    cfg_write(REG_DIFF_MODE, mode);
  endtask

  // n_samples of zero streams the whole volume; drain sends one stride of flush items
  task automatic stream_volume(int unsigned n_samples, bit drain, int early_pct, int late_pct,
                               bit mid_pause, bit pattern);
    int unsigned     c, nx, ny, nz, stride, total;
    bit [SAMPLE_W-1:0] re;
    bit [SAMPLE_W-1:0] im;
    sb.dims(c, nx, ny, nz, stride, total);
    if (n_samples == 0) n_samples = total;
    for (int unsigned i = 0; i < n_samples; i++) begin
      if ($urandom_range(0, 99) < early_pct)
        send_item(REQ_FLUSH, pick_component(), pick_component());
      if (mid_pause && i == n_samples / 2) begin
        wait_idle();
        cfg_write(REG_PAST_END_LO, $urandom);
        cfg_write(REG_PAST_END_HI, $urandom);
      end
      re = pattern ? EDGE_VALS[i % 4] : pick_component();
      im = pattern ? EDGE_VALS[(i + 2) % 4] : pick_component();
      send_item(REQ_SAMPLE, re, im);
      items_sent++;
    end
    if (drain) begin
      for (int unsigned i = 0; i < stride; i++) begin
        // a sample past the volume end counts as a flush
        send_item(($urandom_range(0, 99) < late_pct) ? REQ_SAMPLE : REQ_FLUSH,
                  pick_component(), pick_component());
        items_sent++;
      end
    end
  endtask

  initial begin
    bit          first;
    int unsigned ch;
    int unsigned top;
    sb           = new();
    items_sent   = 0;
    gap_pct      = 0;
    hold_off_req = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= REQ_SAMPLE;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_NUM_CHANNELS;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: smallest volume, extreme components, early flush, late sample
    set_config(1, 3, 3, 3, AXIS_X, DM_CEN);
    send_item(REQ_FLUSH, 16'hFFFF, 16'hFFFF);
    stream_volume(0, 1'b1, 0, 100, 1'b0, 1'b1);

    // Saturating register values; receiver holds off while the sender keeps offering
    set_config(15, 127, 127, 2047, AXIS_X, DM_CEN);
    hold_off_req = 1'b1;
    stream_volume(120, 1'b0, 5, 0, 1'b0, 1'b0);

    // Largest in-range sizes, partial volume, restarted by the next write
    gap_pct = 20;
    set_config(1, 64, 64, 1024, AXIS_Y, DM_FWD);
    stream_volume(200, 1'b0, 0, 0, 1'b0, 1'b0);

    // Random small volumes, some back to back with no config change
    first = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 40;
      endcase
      if (first || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0:       ch = 0;
          1:       ch = $urandom_range(8, 15);
          default: ch = $urandom_range(1, 2);
        endcase
        top = (ch > 2) ? 3 : 6;
        set_config(ch, $urandom_range(0, top), $urandom_range(0, top), $urandom_range(1, top),
                   $urandom_range(0, 3), $urandom_range(0, 3));
      end
      first = 1'b0;
      stream_volume(0, 1'b1, ($urandom_range(0, 3) == 0) ? 10 : 0,
                    ($urandom_range(0, 1) != 0) ? 50 : 0,
                    $urandom_range(0, 7) == 0, 1'b0);
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
